[rtl/dthf_pkg.sv]
package dthf_pkg;

    // Port and field widths
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam int VALUE_W   = 64;
    localparam int PREC_W    = 7;
    localparam int CHAR_W    = 8;

    // binary64 layout
    localparam int FRAC_W = 52;
    localparam int EXPF_W = 11;
    localparam int SIG_W  = FRAC_W + 1;
    localparam int RND_W  = FRAC_W + 2;   // room for a carry into a leading 2

    // Internal widths
    localparam int EXP_W      = 12;       // signed exponent, -1074..1024
    localparam int MAG_W      = 11;
    localparam int REM_W      = 10;
    localparam int NDIG_W     = 6;        // up to 52 fraction digits
    localparam int HEX_DIGITS = 13;
    localparam int FCNT_W     = 4;

    localparam logic [EXPF_W-1:0]        EXPF_SPECIAL   = 11'h7FF;
    localparam logic signed [EXP_W-1:0]  EXP_BIAS       = 12'sd1023;
    localparam logic signed [EXP_W-1:0]  EXP_DENORM     = -12'sd1022;
    localparam logic signed [PREC_W-1:0] PREC_MAX_S     = 7'sd52;
    localparam logic [NDIG_W-1:0]        PREC_MAX       = 6'd52;
    localparam logic [NDIG_W-1:0]        PREC_ROUND_MAX = 6'd12;
    localparam logic [MAG_W-1:0]         MAG_THOUSAND   = 11'd1000;
    localparam logic [22:0]              RECIP_100      = 23'd5243;   // 2^19 / 100
    localparam logic [14:0]              RECIP_10       = 15'd205;    // 2^11 / 10

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_UPPER   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_NORM    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ALT     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PLUS    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MINEXP  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_EXPCH   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_POINTCH = 3'd6;

    // Job queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic              upper_case;
        logic              normalize_mode;
        logic              alt_form;
        logic              plus_sign;
        logic [2:0]        min_exp_digits;
        logic [CHAR_W-1:0] exp_char;
        logic [CHAR_W-1:0] point_char;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        upper_case:     1'b0,
        normalize_mode: 1'b0,
        alt_form:       1'b0,
        plus_sign:      1'b1,
        min_exp_digits: 3'd1,
        exp_char:       8'd112,
        point_char:     8'd46
    };

    // One classified number, ready to be spelled out
    typedef struct packed {
        logic              special;
        logic [1:0]        lead;     // leading digit value 0..2
        logic [FRAC_W-1:0] frac;
        logic [NDIG_W-1:0] ndig;     // fraction digits to print
        logic              neg;      // exponent sign
        logic [15:0]       edig;     // thousands, hundreds, tens, units
        logic [1:0]        epos;     // first exponent digit position shown
    } t_job;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [CHAR_W-1:0] c;
        if (nib < 4'd10) begin
            c = CH_0 + {4'b0, nib};
        end else if (upper) begin
            c = CH_UA + {4'b0, nib - 4'd10};
        end else begin
            c = CH_LA + {4'b0, nib - 4'd10};
        end
        return c;
    endfunction

endpackage

[rtl/dthf_in_if.sv]
interface dthf_in_if;
    import dthf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [VALUE_W-1:0]        value_bits;
    logic signed [PREC_W-1:0]  precision;

    modport source (output valid, output value_bits, output precision, input ready);
    modport sink   (input valid, input value_bits, input precision, output ready);
endinterface

[rtl/dthf_out_if.sv]
interface dthf_out_if;
    import dthf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last;
    logic              special;

    modport source (output valid, output out_char, output last, output special, input ready);
    modport sink   (input valid, input out_char, input last, input special, output ready);
endinterface

[rtl/double_to_hex_float_text_unit.sv]
// Hex-float text formatter. Each request carries the 64 raw bits of a double
// and a signed precision; the unit answers with the text of the number, one
// character per response beat, last set on the final character: leading
// digit, optional point, hex fraction digits, exponent character, exponent
// sign, 1 to 4 decimal exponent digits. No sign and no 0x prefix are produced.
// NaN and infinity give a single beat with char 0 and special set.
// Flow: the front end accepts a request, walks the leading one of a
// denormal in normalize mode up to the hidden position (4 bits or 1 bit a
// cycle), rounds, takes three exponent-digit steps, then drops a job into
// a two-entry queue, waiting while the queue is full, and takes the next
// request. The back end spells one character per cycle unless the output
// stalls, so a number occupies the output for its text length. Throughput
// is set by the back end's one-character-per-cycle output register whenever
// the text takes longer to spell than the front end takes per request;
// output stalls slow it further. The APB registers should only be written
// while the unit is idle.

module double_to_hex_float_text_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dthf_in_if.sink                       i_req,
    dthf_out_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dthf_pkg::ADDR_W-1:0]   paddr,
    input  logic [dthf_pkg::DATA_W-1:0]   pwdata,
    output logic [dthf_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import dthf_pkg::*;

    t_cfg r_cfg, n_cfg;

    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_valid;
    t_job                 q_in_job;
    t_job                 q_out_job;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;

    // ---------------- APB register file ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            case (reg_idx)
                REG_UPPER:   n_cfg.upper_case     = pwdata[0];
                REG_NORM:    n_cfg.normalize_mode = pwdata[0];
                REG_ALT:     n_cfg.alt_form       = pwdata[0];
                REG_PLUS:    n_cfg.plus_sign      = pwdata[0];
                REG_MINEXP:  n_cfg.min_exp_digits = pwdata[2:0];
                REG_EXPCH:   n_cfg.exp_char       = pwdata[CHAR_W-1:0];
                REG_POINTCH: n_cfg.point_char     = pwdata[CHAR_W-1:0];
                default:     n_cfg = r_cfg;       // unmapped: write dropped
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_UPPER:   prdata = DATA_W'(r_cfg.upper_case);
            REG_NORM:    prdata = DATA_W'(r_cfg.normalize_mode);
            REG_ALT:     prdata = DATA_W'(r_cfg.alt_form);
            REG_PLUS:    prdata = DATA_W'(r_cfg.plus_sign);
            REG_MINEXP:  prdata = DATA_W'(r_cfg.min_exp_digits);
            REG_EXPCH:   prdata = DATA_W'(r_cfg.exp_char);
            REG_POINTCH: prdata = DATA_W'(r_cfg.point_char);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // ---------------- front end: accept, classify, round, exponent digits ----
    dthf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_job  (q_in_job)
    );

    // ---------------- job queue: lets either side stall alone ----------------
    dthf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_out_job)
    );

    // ---------------- back end: one character per cycle ----------------
    dthf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_job     (q_out_job),
        .o_q_pop   (q_pop),
        .o_rsp     (o_rsp)
    );

endmodule

[rtl/dthf_front.sv]
module dthf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dthf_pkg::t_cfg i_cfg,
    dthf_in_if.sink        i_req,
    input  logic           i_q_full,
    output logic           o_q_push,
    output dthf_pkg::t_job o_q_job
);
    import dthf_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_NORM  = 6'b000010,
        S_ROUND = 6'b000100,
        S_DEC1  = 6'b001000,
        S_DEC2  = 6'b010000,
        S_DEC3  = 6'b100000
    } t_fstate;

    t_fstate r_state, n_state;

    logic                     r_special, n_special;
    logic                     r_zero, n_zero;
    logic                     r_short, n_short;
    logic [NDIG_W-1:0]        r_prec, n_prec;
    logic [SIG_W-1:0]         r_sig, n_sig;
    logic signed [EXP_W-1:0]  r_exp, n_exp;
    logic [1:0]               r_lead, n_lead;
    logic [NDIG_W-1:0]        r_ndig, n_ndig;
    logic                     r_neg, n_neg;
    logic                     r_thou, n_thou;
    logic [REM_W-1:0]         r_rem, n_rem;
    logic [3:0]               r_hund, n_hund;

    // request decode
    logic [EXPF_W-1:0]        in_ex;
    logic                     in_zero;
    logic                     in_special;
    logic                     in_short;
    logic [NDIG_W-1:0]        in_prec;
    logic signed [EXP_W-1:0]  in_exp;

    // rounding
    logic                     rnd_en;
    logic [NDIG_W-1:0]        rnd_sh;
    logic [RND_W-1:0]         rnd_unit;
    logic                     rnd_bit;
    logic [RND_W-1:0]         rnd_sum;
    logic [RND_W-1:0]         rnd_val;

    // digit count and exponent digits
    logic [FCNT_W-1:0]        fcnt;
    logic [EXP_W-1:0]         mag_full;
    logic [MAG_W-1:0]         mag;
    logic [MAG_W-1:0]         mag_rem;
    logic [22:0]              hund_prod;
    logic [REM_W-1:0]         rem2;
    logic [14:0]              tens_prod;
    logic [3:0]               tens;
    logic [6:0]               unit7;
    logic                     need4, need3, need2;
    logic [1:0]               epos;

    assign i_req.ready = (r_state == S_IDLE);

    assign in_ex      = i_req.value_bits[FRAC_W+EXPF_W-1:FRAC_W];
    assign in_zero    = (i_req.value_bits[FRAC_W+EXPF_W-1:0] == '0);
    assign in_special = (in_ex == EXPF_SPECIAL);
    assign in_short   = (i_req.precision < 0);
    assign in_prec    = (i_req.precision > PREC_MAX_S) ? PREC_MAX
                                                      : i_req.precision[NDIG_W-1:0];
    assign in_exp     = in_zero ? '0
                      : (in_ex == '0) ? EXP_DENORM
                      : $signed({1'b0, in_ex}) - EXP_BIAS;

    assign rnd_en   = !r_short && (r_prec <= PREC_ROUND_MAX);
    assign rnd_sh   = NDIG_W'(FRAC_W) - {r_prec[3:0], 2'b00};
    assign rnd_unit = RND_W'(1) << rnd_sh;
    assign rnd_bit  = r_sig[rnd_sh - NDIG_W'(1)];
    assign rnd_sum  = {1'b0, r_sig} + (rnd_bit ? rnd_unit : '0);
    assign rnd_val  = rnd_en ? (rnd_sum & ~(rnd_unit - RND_W'(1))) : {1'b0, r_sig};

    // last nonzero hex digit of the fraction
    always_comb begin
        fcnt = '0;
        for (int i = 0; i < HEX_DIGITS; i++) begin
            if (r_sig[FRAC_W-1-4*i -: 4] != 4'd0) begin
                fcnt = FCNT_W'(i + 1);
            end
        end
    end

    assign mag_full  = r_exp[EXP_W-1] ? EXP_W'(-r_exp) : EXP_W'(r_exp);
    assign mag       = mag_full[MAG_W-1:0];
    assign mag_rem   = (mag >= MAG_THOUSAND) ? mag - MAG_THOUSAND : mag;
    assign hund_prod = 23'(r_rem) * RECIP_100;
    assign rem2      = r_rem - (REM_W'({r_hund, 6'b0}) + REM_W'({r_hund, 5'b0})
                              + REM_W'({r_hund, 2'b0}));
    assign tens_prod = 15'(rem2[6:0]) * RECIP_10;
    assign tens      = tens_prod[14:11];
    assign unit7     = rem2[6:0] - (7'({tens, 3'b0}) + 7'({tens, 1'b0}));

    assign need4 = r_thou || (i_cfg.min_exp_digits >= 3'd4);
    assign need3 = need4 || (r_hund != 4'd0) || (i_cfg.min_exp_digits >= 3'd3);
    assign need2 = need3 || (tens != 4'd0) || (i_cfg.min_exp_digits >= 3'd2);
    assign epos  = need4 ? 2'd0 : need3 ? 2'd1 : need2 ? 2'd2 : 2'd3;

    always_comb begin
        o_q_job.special = r_special;
        o_q_job.lead    = r_lead;
        o_q_job.frac    = r_sig[FRAC_W-1:0];
        o_q_job.ndig    = r_ndig;
        o_q_job.neg     = r_neg;
        o_q_job.edig    = {3'b000, r_thou, r_hund, tens, unit7[3:0]};
        o_q_job.epos    = epos;
    end

    always_comb begin
        n_state   = r_state;
        n_special = r_special;
        n_zero    = r_zero;
        n_short   = r_short;
        n_prec    = r_prec;
        n_sig     = r_sig;
        n_exp     = r_exp;
        n_lead    = r_lead;
        n_ndig    = r_ndig;
        n_neg     = r_neg;
        n_thou    = r_thou;
        n_rem     = r_rem;
        n_hund    = r_hund;
        o_q_push  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_special = in_special;
                    n_zero    = in_zero;
                    n_short   = in_short;
                    n_prec    = in_prec;
                    n_sig     = {!i_cfg.normalize_mode && (in_ex != '0),
                                 i_req.value_bits[FRAC_W-1:0]};
                    n_exp     = in_exp;
                    n_state   = (i_cfg.normalize_mode && (in_ex == '0) && !in_zero)
                              ? S_NORM : S_ROUND;
                end
            end
            S_NORM: begin
                // denormal: walk the leading one up to the hidden position
                if (r_sig[FRAC_W]) begin
                    n_sig[FRAC_W] = 1'b0;
                    n_state       = S_ROUND;
                end else if (r_sig[FRAC_W -: 4] == 4'd0) begin
                    n_sig = {r_sig[SIG_W-5:0], 4'b0000};
                    n_exp = r_exp - 12'sd4;
                end else begin
                    n_sig = {r_sig[SIG_W-2:0], 1'b0};
                    n_exp = r_exp - 12'sd1;
                end
            end
            S_ROUND: begin
                n_sig = {1'b0, rnd_val[FRAC_W-1:0]};
                if (r_zero) begin
                    n_lead = 2'd0;
                end else if (i_cfg.normalize_mode) begin
                    n_lead = 2'd1;
                    if (rnd_val[FRAC_W]) begin
                        n_exp = r_exp + 12'sd1;
                    end
                end else begin
                    n_lead = rnd_val[RND_W-1:FRAC_W];
                end
                n_state = S_DEC1;
            end
            S_DEC1: begin
                if (r_short || (NDIG_W'(fcnt) > r_prec)) begin
                    n_ndig = NDIG_W'(fcnt);
                end else begin
                    n_ndig = r_prec;
                end
                n_neg   = r_exp[EXP_W-1];
                n_thou  = (mag >= MAG_THOUSAND);
                n_rem   = mag_rem[REM_W-1:0];
                n_state = S_DEC2;
            end
            S_DEC2: begin
                n_hund  = hund_prod[22:19];
                n_state = S_DEC3;
            end
            S_DEC3: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_special <= n_special;
        r_zero    <= n_zero;
        r_short   <= n_short;
        r_prec    <= n_prec;
        r_sig     <= n_sig;
        r_exp     <= n_exp;
        r_lead    <= n_lead;
        r_ndig    <= n_ndig;
        r_neg     <= n_neg;
        r_thou    <= n_thou;
        r_rem     <= n_rem;
        r_hund    <= n_hund;
    end

endmodule

[rtl/dthf_queue.sv]
module dthf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dthf_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output dthf_pkg::t_job o_job
);
    import dthf_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, n_wptr;
    logic [Q_PTR_W-1:0] r_rptr, n_rptr;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr = do_push ? r_wptr + Q_PTR_W'(1) : r_wptr;
        n_rptr = do_pop ? r_rptr + Q_PTR_W'(1) : r_rptr;
        n_cnt  = r_cnt + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

[rtl/dthf_back.sv]
module dthf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dthf_pkg::t_cfg i_cfg,
    input  logic           i_q_valid,
    input  dthf_pkg::t_job i_job,
    output logic           o_q_pop,
    dthf_out_if.source     o_rsp
);
    import dthf_pkg::*;

    typedef enum logic [5:0] {
        B_LEAD  = 6'b000001,
        B_POINT = 6'b000010,
        B_FRAC  = 6'b000100,
        B_ECHAR = 6'b001000,
        B_SIGN  = 6'b010000,
        B_EDIG  = 6'b100000
    } t_bstate;

    t_bstate           r_bstate, n_bstate;
    logic              r_ovalid, n_ovalid;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_last, n_last;
    logic              r_special, n_special;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic [NDIG_W-1:0] r_cnt, n_cnt;
    logic [1:0]        r_epos, n_epos;
    logic              adv;
    logic [3:0]        edigit;

    assign o_rsp.valid    = r_ovalid;
    assign o_rsp.out_char = r_char;
    assign o_rsp.last     = r_last;
    assign o_rsp.special  = r_special;

    // a new character goes out whenever a job is waiting and the output register is free or drains
    assign adv = i_q_valid && (!r_ovalid || o_rsp.ready);

    always_comb begin
        case (r_epos)
            2'd0:    edigit = i_job.edig[15:12];
            2'd1:    edigit = i_job.edig[11:8];
            2'd2:    edigit = i_job.edig[7:4];
            default: edigit = i_job.edig[3:0];
        endcase
    end

    always_comb begin
        n_bstate  = r_bstate;
        n_ovalid  = r_ovalid && !o_rsp.ready;
        n_char    = r_char;
        n_last    = r_last;
        n_special = r_special;
        n_frac    = r_frac;
        n_cnt     = r_cnt;
        n_epos    = r_epos;
        o_q_pop   = 1'b0;
        if (adv) begin
            n_ovalid  = 1'b1;
            n_last    = 1'b0;
            n_special = 1'b0;
            case (r_bstate)
                B_LEAD: begin
                    if (i_job.special) begin
                        n_char    = CH_NUL;
                        n_last    = 1'b1;
                        n_special = 1'b1;
                        o_q_pop   = 1'b1;
                    end else begin
                        n_char   = hex_char({2'b00, i_job.lead}, i_cfg.upper_case);
                        n_frac   = i_job.frac;
                        n_cnt    = '0;
                        n_bstate = ((i_job.ndig != '0) || i_cfg.alt_form) ? B_POINT : B_ECHAR;
                    end
                end
                B_POINT: begin
                    n_char   = i_cfg.point_char;
                    n_bstate = (i_job.ndig != '0) ? B_FRAC : B_ECHAR;
                end
                B_FRAC: begin
                    n_char = hex_char(r_frac[FRAC_W-1 -: 4], i_cfg.upper_case);
                    n_frac = {r_frac[FRAC_W-5:0], 4'b0000};
                    n_cnt  = r_cnt + NDIG_W'(1);
                    if (r_cnt == i_job.ndig - NDIG_W'(1)) begin
                        n_bstate = B_ECHAR;
                    end
                end
                B_ECHAR: begin
                    n_char   = i_cfg.exp_char;
                    n_epos   = i_job.epos;
                    n_bstate = (i_job.neg || i_cfg.plus_sign) ? B_SIGN : B_EDIG;
                end
                B_SIGN: begin
                    n_char   = i_job.neg ? CH_MINUS : CH_PLUS;
                    n_bstate = B_EDIG;
                end
                B_EDIG: begin
                    n_char = CH_0 + {4'b0000, edigit};
                    if (r_epos == 2'd3) begin
                        n_last   = 1'b1;
                        o_q_pop  = 1'b1;
                        n_bstate = B_LEAD;
                    end else begin
                        n_epos = r_epos + 2'd1;
                    end
                end
                default: begin
                    n_bstate = B_LEAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate <= B_LEAD;
            r_ovalid <= 1'b0;
        end else begin
            r_bstate <= n_bstate;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char    <= n_char;
        r_last    <= n_last;
        r_special <= n_special;
        r_frac    <= n_frac;
        r_cnt     <= n_cnt;
        r_epos    <= n_epos;
    end

endmodule

[rtl/dthf_checker.sv]
module dthf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic [dthf_pkg::CHAR_W-1:0]   i_char,
    input logic                          i_last,
    input logic                          i_special
);
    import dthf_pkg::*;

    // nothing leaves the unit right after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("response valid right after reset");

    // NaN/infinity is a lone NUL beat
    a_special_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_special |-> i_last && (i_char == CH_NUL))
        else $error("special beat is not a single NUL");

    // text always ends on an exponent digit
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last && !i_special |-> (i_char >= CH_0) && (i_char <= CH_9))
        else $error("text does not end on a decimal digit");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_char) && $stable(i_last))
        else $error("stalled response changed");

endmodule

bind double_to_hex_float_text_unit dthf_checker u_dthf_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_rsp.valid),
    .i_ready   (o_rsp.ready),
    .i_char    (o_rsp.out_char),
    .i_last    (o_rsp.last),
    .i_special (o_rsp.special)
);

[tb/sv/dthf_text_check.sv]
module dthf_text_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dthf_in_if                          i_req,
    dthf_out_if                         i_rsp,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [dthf_pkg::ADDR_W-1:0] i_paddr,
    input  logic [dthf_pkg::DATA_W-1:0] i_pwdata,
    output int                          o_fail_count,
    output int                          o_chars_due
);
    import dthf_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              special;
    } t_text_beat;

    typedef t_text_beat t_beat_q[$];

    t_cfg       cfg_copy;
    t_text_beat chars_due[$];
    t_beat_q    fresh;
    t_text_beat want;
    t_text_beat got;
    int         fails = 0;

    function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] nib, input logic upper);
        if (nib <= 4'd9) begin
            return CH_0 + {4'd0, nib};
        end
        return (upper ? CH_UA : CH_LA) + {4'd0, nib} - 8'd10;
    endfunction

    // Spell one number as hex-float text under the given register settings.
    function automatic t_beat_q spell_hex_float(input logic [VALUE_W-1:0] bits,
                                                input logic signed [PREC_W-1:0] prec_in,
                                                input t_cfg c);
        t_beat_q           beats;
        logic [CHAR_W-1:0] digs[$];
        logic [CHAR_W-1:0] txt[$];
        logic [63:0]       sig;
        logic [63:0]       step;
        logic [10:0]       bexp;
        int                prec;
        int                e;
        int                mag;
        int                sh;
        int                i;
        prec = prec_in;
        if (prec < -1) prec = -1;
        if (prec > 52) prec = 52;
        bexp = bits[62:52];
        if (bexp == EXPF_SPECIAL) begin
            beats.push_back('{ch: CH_NUL, last: 1'b1, special: 1'b1});
            return beats;
        end
        if (bits[62:0] == '0) begin
            digs.push_back(CH_0);
            e = 0;
        end else begin
            sig = {12'd0, bits[51:0]};
            e = int'(bexp) - int'(EXP_BIAS);
            if (c.normalize_mode) begin
                if (bexp == '0) begin
                    e++;
                    while (!sig[52]) begin
                        sig = sig << 1;
                        e--;
                    end
                    sig[63:52] = '0;
                end
            end else if (bexp == '0) begin
                e++;
            end else begin
                sig[52] = 1'b1;
            end
            // round half up at the last kept digit, then cut
            if (prec >= 0 && prec <= 12) begin
                sh = 52 - 4 * prec;
                step = 64'd1 << sh;
                if (sig[sh-1]) begin
                    sig = sig + step;
                    if (c.normalize_mode && sig[52]) e++;
                end
                sig = sig & ~(step - 64'd1);
            end
            digs.push_back(hex_digit(c.normalize_mode ? 4'd1 : sig[55:52], c.upper_case));
            sig = sig << 12;
            while (sig != 0 && digs.size() < 14) begin
                digs.push_back(hex_digit(sig[63:60], c.upper_case));
                sig = sig << 4;
            end
        end

        txt.push_back(digs[0]);
        if (digs.size() > 1) begin
            txt.push_back(c.point_char);
            for (i = 1; i < digs.size(); i++) txt.push_back(digs[i]);
            for (i = digs.size() - 1; i < prec; i++) txt.push_back(CH_0);
        end else if (prec > 0) begin
            txt.push_back(c.point_char);
            repeat (prec) txt.push_back(CH_0);
        end else if (c.alt_form) begin
            txt.push_back(c.point_char);
        end

        txt.push_back(c.exp_char);
        mag = (e < 0) ? -e : e;
        if (e < 0) txt.push_back(CH_MINUS);
        else if (c.plus_sign) txt.push_back(CH_PLUS);
        if (mag >= 1000 || c.min_exp_digits >= 3'd4) txt.push_back(CH_0 + 8'(mag / 1000));
        if (mag >= 100 || c.min_exp_digits >= 3'd3) txt.push_back(CH_0 + 8'((mag / 100) % 10));
        if (mag >= 10 || c.min_exp_digits >= 3'd2) txt.push_back(CH_0 + 8'((mag / 10) % 10));
        txt.push_back(CH_0 + 8'(mag % 10));

        for (i = 0; i < txt.size(); i++) begin
            beats.push_back('{ch: txt[i], last: (i == txt.size() - 1), special: 1'b0});
        end
        return beats;
    endfunction

    task automatic note_fail(input string what, input t_text_beat exp_b, input t_text_beat act_b);
        fails++;
        if (fails <= 10) begin
            $display("%0t: %s: expected char %02h last %0b special %0b",
                     $realtime, what, exp_b.ch, exp_b.last, exp_b.special,
                     ", got char %02h last %0b special %0b",
                     act_b.ch, act_b.last, act_b.special);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_copy = CFG_RESET;
            chars_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_UPPER:   cfg_copy.upper_case     = i_pwdata[0];
                    REG_NORM:    cfg_copy.normalize_mode = i_pwdata[0];
                    REG_ALT:     cfg_copy.alt_form       = i_pwdata[0];
                    REG_PLUS:    cfg_copy.plus_sign      = i_pwdata[0];
                    REG_MINEXP:  cfg_copy.min_exp_digits = i_pwdata[2:0];
                    REG_EXPCH:   cfg_copy.exp_char       = i_pwdata[CHAR_W-1:0];
                    REG_POINTCH: cfg_copy.point_char     = i_pwdata[CHAR_W-1:0];
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                fresh = spell_hex_float(i_req.value_bits, i_req.precision, cfg_copy);
                foreach (fresh[k]) chars_due.push_back(fresh[k]);
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{ch: i_rsp.out_char, last: i_rsp.last, special: i_rsp.special};
                if (chars_due.size() == 0) begin
                    note_fail("unexpected character", '0, got);
                end else begin
                    want = chars_due.pop_front();
                    if (want.ch !== got.ch || want.last !== got.last
                            || want.special !== got.special) begin
                        note_fail("character mismatch", want, got);
                    end
                end
            end
        end
        o_chars_due  <= chars_due.size();
        o_fail_count <= fails;
    end

endmodule

[tb/sv/tb_double_to_hex_float_text_unit.sv]
module tb_double_to_hex_float_text_unit;
    import dthf_pkg::*;

    // Generous: ~180 requests of at most 60 chars each, with receiver stalls,
    // one long hold and the config drains fit well inside this.
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_SETTING = 26;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    dthf_in_if  req_ch();
    dthf_out_if rsp_ch();

    int fail_count;
    int chars_due;
    int cycle_count   = 0;
    int tx_gap_pct    = 38;   // chance per cycle that the sender idles
    int rx_gap_pct    = 45;   // chance per cycle that the receiver stalls
    bit long_hold_ask = 1'b0; // set by stimulus, consumed by the receiver

    double_to_hex_float_text_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Watches both channels and the register port, predicts every character.
    dthf_text_check text_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_chars_due  (chars_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: a hung block or a lost character ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Response side. Random stalls per phase, plus one long hold on request
    // so the job queue fills and the block pushes back on its input.
    initial begin
        int hold_left;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (long_hold_ask) begin
                long_hold_ask = 1'b0;
                hold_left = 399;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rx_gap_pct);
            end
        end
    end

    // Offer one request, with random idle cycles in front of it. Valid is
    // only lowered when a gap is actually taken, so back-to-back requests
    // keep it high.
    task automatic send_req(input logic [VALUE_W-1:0] bits, input logic signed [PREC_W-1:0] prec);
        while ($urandom_range(99) < tx_gap_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.value_bits <= bits;
        req_ch.precision  <= prec;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Stop offering and wait for every predicted character to come back.
    // The first edge lets the checker count the request just accepted.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (chars_due != 0) @(posedge i_clk);
    endtask

    // One APB write: setup, then access until pready. psel stays up so that
    // writes chain; apply_cfg drops it after the last one.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    // Only called while the block is idle.
    task automatic apply_cfg(input t_cfg c);
        write_reg(REG_UPPER,   DATA_W'(c.upper_case));
        write_reg(REG_NORM,    DATA_W'(c.normalize_mode));
        write_reg(REG_ALT,     DATA_W'(c.alt_form));
        write_reg(REG_PLUS,    DATA_W'(c.plus_sign));
        write_reg(REG_MINEXP,  DATA_W'(c.min_exp_digits));
        write_reg(REG_EXPCH,   DATA_W'(c.exp_char));
        write_reg(REG_POINTCH, DATA_W'(c.point_char));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.upper_case     = 1'($urandom_range(1));
        c.normalize_mode = 1'($urandom_range(1));
        c.alt_form       = 1'($urandom_range(1));
        c.plus_sign      = 1'($urandom_range(1));
        // mostly the legal 1..4, sometimes 0 or 5..7
        c.min_exp_digits = ($urandom_range(3) == 0) ? 3'($urandom_range(7))
                                                    : 3'($urandom_range(4, 1));
        c.exp_char       = 8'($urandom_range(255));
        c.point_char     = 8'($urandom_range(255));
        return c;
    endfunction

    // Values biased toward the interesting corners: denormals, short
    // fractions, rounding carries, near-unity and extreme exponents.
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        logic [51:0]        frac;
        logic [10:0]        ex;
        v    = {$urandom, $urandom};
        frac = v[51:0];
        ex   = v[62:52];
        case ($urandom_range(9))
            0, 1: ;
            2, 3: ex = 11'd1003 + 11'($urandom_range(40));
            4: begin
                ex   = '0;
                frac = frac >> $urandom_range(51);
            end
            5: frac = frac & ~(52'hF_FFFF_FFFF_FFFF >> (4 * $urandom_range(13)));
            6: frac = frac | (52'hF_FFFF_FFFF_FFFF >> (4 * $urandom_range(12, 1)));
            7: frac = frac | (52'h8 << (4 * $urandom_range(12)));
            8: begin
                // zero, denormal, infinity or NaN
                ex   = $urandom_range(1) ? EXPF_SPECIAL : 11'd0;
                frac = $urandom_range(1) ? 52'd0 : frac;
            end
            default: ex = $urandom_range(1) ? 11'h7FE - 11'($urandom_range(3))
                                            : 11'd1 + 11'($urandom_range(3));
        endcase
        v[62:52] = ex;
        v[51:0]  = frac;
        return v;
    endfunction

    // Mostly short precisions; a few long ones and out-of-range codes.
    function automatic logic signed [PREC_W-1:0] random_prec();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return PREC_W'(int'($urandom_range(14)) - 1);
            6:       return PREC_W'($urandom_range(52, 14));
            7, 8:    return -7'sd1;
            default: return PREC_W'($urandom);
        endcase
    endfunction

    task automatic run_directed();
        // reset settings: lower case, no normalize, '+' shown, 'p' and '.'
        send_req(64'h0000_0000_0000_0000, -7'sd1);   // positive zero
        send_req(64'h8000_0000_0000_0000, 7'sd3);    // negative zero, zero padding
        send_req(64'h7FF0_0000_0000_0000, 7'sd0);    // infinity
        send_req(64'hFFF8_0000_0000_0001, -7'sd1);   // NaN with sign set
        send_req(64'h3FF0_0000_0000_0000, -7'sd1);   // exactly one
        send_req(64'h3FFF_FFFF_FFFF_FFFF, 7'sd0);    // carry into a leading 2
        send_req(64'h7FEF_FFFF_FFFF_FFFF, 7'sd12);   // largest normal, carry at last digit
        send_req(64'h0000_0000_0000_0001, -7'sd1);   // smallest denormal
        send_req(64'h000F_FFFF_FFFF_FFFF, 7'sd0);    // denormal rounds up to leading 1
        send_req(64'h3FF8_0000_0000_0000, 7'sd52);   // longest text
        send_req(64'hBFF4_0000_0000_0000, 7'sd63);   // saturates at 52
        send_req(64'h4009_21FB_5444_2D18, 7'sh40);   // most negative code -> shortest
        send_req(64'h4009_21FB_5444_2D18, -7'sd2);
        send_req(64'h0010_0000_0000_0000, 7'sd5);    // smallest normal
        send_req(64'hC3E5_A5A5_A5A5_A5A5, 7'sd13);   // first padding-only precision
        send_req(64'h3FF8_0000_0000_0000, 7'sd0);    // exact half rounds up
        wait_drained();

        // normalize, upper case, alt form, no plus, four exponent digits
        apply_cfg('{upper_case: 1'b1, normalize_mode: 1'b1, alt_form: 1'b1, plus_sign: 1'b0,
                    min_exp_digits: 3'd4, exp_char: 8'hFF, point_char: 8'h00});
        send_req(64'h0000_0000_0000_0001, -7'sd1);   // renormalized, exponent -1074
        send_req(64'h000F_FFFF_FFFF_FFFF, 7'sd0);    // carry bumps the exponent
        send_req(64'h0000_0000_0000_0000, 7'sd0);    // zero keeps digit 0, point shown
        send_req(64'h3FFF_FFFF_FFFF_FFFF, 7'sd3);
        send_req(64'h7FEA_BCDE_F012_3456, -7'sd1);   // upper-case letters
        wait_drained();

        // min digits 0 acts as 1; odd separator codes
        apply_cfg('{upper_case: 1'b0, normalize_mode: 1'b0, alt_form: 1'b0, plus_sign: 1'b1,
                    min_exp_digits: 3'd0, exp_char: 8'h00, point_char: 8'hFF});
        send_req(64'h3FB9_9999_9999_999A, 7'sd4);
        send_req(64'h3FF0_0000_0000_0000, 7'sd0);    // no point without alt form
        wait_drained();

        // min digits 7 acts as 4
        apply_cfg('{upper_case: 1'b1, normalize_mode: 1'b0, alt_form: 1'b1, plus_sign: 1'b1,
                    min_exp_digits: 3'd7, exp_char: 8'h50, point_char: 8'h2C});
        send_req(64'h000A_BCDE_F000_0000, -7'sd1);
        send_req(64'h4000_0000_0000_0000, 7'sd0);
    endtask

    // Main sequence: reset, directed corners, then three idle profiles with
    // two register settings each; the block drains before each setting.
    initial begin
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.value_bits <= '0;
        req_ch.precision  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_gap_pct = 38; rx_gap_pct = 45; end
                1: begin tx_gap_pct = 45; rx_gap_pct = 38; end
                default: begin tx_gap_pct = 0; rx_gap_pct = 0; end
            endcase
            for (int half = 0; half < 2; half++) begin
                wait_drained();
                apply_cfg(random_cfg());
                for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
                    // long receiver hold while requests keep coming
                    if (phase == 0 && half == 0 && n == 8) long_hold_ask = 1'b1;
                    send_req(random_value(), random_prec());
                end
            end
        end

        wait_drained();
        // a stray extra character would show up within this tail
        repeat (80) @(posedge i_clk);
        if (fail_count == 0 && chars_due == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
